// ===== hw/rtl/bfa_pkg.sv =====
`timescale 1ns / 1ps

package bfa_pkg;

  // default geometry
  localparam int POOL_BYTES_DEF   = 4096;
  localparam int HEADER_BYTES_DEF = 40;
  localparam int MIN_SPLIT_DEF    = 32;

  // fixed field widths
  localparam int ACT_W   = 2;
  localparam int REQ_W   = 13;
  localparam int ADDR_W  = 12;
  localparam int STAT_W  = 2;
  localparam int CFG_W   = 13;
  localparam int STAMP_W = 32;
  localparam int NEED_W  = 12;

  localparam logic [CFG_W-1:0] CFG_RESET = 13'd4096;

  // action codes
  localparam logic [ACT_W-1:0] ACT_ALLOC = 2'd0;
  localparam logic [ACT_W-1:0] ACT_FREE  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_INIT  = 2'd2;
  localparam logic [ACT_W-1:0] ACT_RSVD  = 2'd3;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOFIT   = 2'd1;
  localparam logic [STAT_W-1:0] ST_BADFREE = 2'd2;
  localparam logic [STAT_W-1:0] ST_INITF   = 2'd3;

endpackage

// ===== hw/rtl/best_fit_block_allocator_unit.sv =====
`timescale 1ns / 1ps
// Best-fit allocator, sequential: busy is high while one request runs.
// Allocate: a scan over the pool's granules (one granule table read per cycle).
// Free: walk down the table to the previous block, then look at the next block.
// Init: a table clearing sweep over POOL_BYTES/8 entries. Others: answered from idle.
// Result is one done_o cycle; the receiver cannot stall. Reset clears control only.
module best_fit_block_allocator_unit #(
  parameter int POOL_BYTES   = bfa_pkg::POOL_BYTES_DEF,
  parameter int HEADER_BYTES = bfa_pkg::HEADER_BYTES_DEF,
  parameter int MIN_SPLIT    = bfa_pkg::MIN_SPLIT_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [bfa_pkg::ACT_W-1:0]    action_i,
  input  logic [bfa_pkg::REQ_W-1:0]    req_bytes_i,
  input  logic [bfa_pkg::ADDR_W-1:0]   address_i,
  output logic                         done_o,
  output logic [bfa_pkg::STAT_W-1:0]   status_o,
  output logic [bfa_pkg::ADDR_W-1:0]   data_address_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [bfa_pkg::CFG_W-1:0]    cfg_data_i
);

  localparam int NGRAN   = POOL_BYTES / 8;
  localparam int IW      = $clog2(NGRAN);
  localparam int GW      = $clog2(NGRAN + 1);
  localparam int XW      = ((IW > bfa_pkg::NEED_W) ? IW : bfa_pkg::NEED_W) + 2;
  localparam int FW      = (GW > 9) ? GW : 9;
  localparam int SPLIT_G = (MIN_SPLIT + 7) / 8;
  localparam int SW      = bfa_pkg::STAMP_W;

  // sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_INIT   = 4'd1;
  localparam logic [3:0] S_INIT_W = 4'd2;
  localparam logic [3:0] S_SCAN   = 4'd3;
  localparam logic [3:0] S_A_WR   = 4'd4;
  localparam logic [3:0] S_A_SPL  = 4'd5;
  localparam logic [3:0] S_F_CHK  = 4'd6;
  localparam logic [3:0] S_F_WALK = 4'd7;
  localparam logic [3:0] S_F_CLRG = 4'd8;
  localparam logic [3:0] S_F_MARK = 4'd9;
  localparam logic [3:0] S_F_NRD  = 4'd10;
  localparam logic [3:0] S_F_NCHK = 4'd11;
  localparam logic [3:0] S_F_NCLR = 4'd12;

  logic [3:0]                 state_q, state_d;
  logic [IW:0]                idx_q, idx_d;
  logic                       chk_v_q, chk_v_d;
  logic [IW-1:0]              chk_idx_q, chk_idx_d;
  logic                       walk_more_q, walk_more_d;
  logic [bfa_pkg::NEED_W-1:0] need_q, need_d;
  logic [IW-1:0]              g_q, g_d;
  logic [IW-1:0]              cur_q, cur_d;
  logic [GW-1:0]              cur_gran_q, cur_gran_d;
  logic [SW-1:0]              cur_stamp_q, cur_stamp_d;
  logic [IW-1:0]              n_q, n_d;
  logic                       best_v_q, best_v_d;
  logic [IW-1:0]              best_idx_q, best_idx_d;
  logic [GW-1:0]              best_gran_q, best_gran_d;
  logic [SW-1:0]              best_stamp_q, best_stamp_d;
  logic [SW-1:0]              stamp_q, stamp_d;
  logic                       ready_q, ready_d;
  logic [GW-1:0]              pool_gran_q, pool_gran_d;
  logic [bfa_pkg::CFG_W-1:0]  cfg_q;
  logic                       done_q, done_d;
  logic [bfa_pkg::STAT_W-1:0] status_q, status_d;
  logic [bfa_pkg::ADDR_W-1:0] addr_q, addr_d;

  // table port
  logic                       mem_we;
  logic [IW-1:0]              mem_wa;
  logic                       mem_ws, mem_wf;
  logic [GW-1:0]              mem_wg;
  logic [SW-1:0]              mem_wt;
  logic [IW-1:0]              mem_ra;
  logic                       rd_s, rd_f;
  logic [GW-1:0]              rd_g;
  logic [SW-1:0]              rd_t;
  logic                       take;

  bfa_mem #(.IW(IW), .GW(GW)) u_mem (
    .clk_i    (clk_i),
    .we_i     (mem_we),
    .waddr_i  (mem_wa),
    .wstart_i (mem_ws),
    .wfree_i  (mem_wf),
    .wgran_i  (mem_wg),
    .wstamp_i (mem_wt),
    .raddr_i  (mem_ra),
    .rstart_o (rd_s),
    .rfree_o  (rd_f),
    .rgran_o  (rd_g),
    .rstamp_o (rd_t)
  );

  bfa_pick #(.GW(GW)) u_pick (
    .cand_start_i (rd_s),
    .cand_free_i  (rd_f),
    .cand_gran_i  (rd_g),
    .cand_stamp_i (rd_t),
    .need_i       (need_q),
    .best_v_i     (best_v_q),
    .best_gran_i  (best_gran_q),
    .best_stamp_i (best_stamp_q),
    .take_o       (take)
  );

  // init sizing
  logic [17:0] cfg_ext, cfg_sat, cfg_round;
  logic        init_ok;
  logic [GW-1:0] init_gran;
  assign cfg_ext   = 18'(cfg_q);
  assign cfg_sat   = (cfg_ext > 18'(POOL_BYTES)) ? 18'(POOL_BYTES) : cfg_ext;
  assign cfg_round = {cfg_sat[17:3], 3'b000};
  assign init_ok   = (cfg_round >= 18'(MIN_SPLIT)) && (cfg_round >= 18'd8);
  assign init_gran = GW'(cfg_sat >> 3);

  // allocate size in granules
  logic [14:0]                need_b;
  logic [bfa_pkg::NEED_W-1:0] need_g;
  assign need_b = 15'(req_bytes_i) + 15'(HEADER_BYTES) + 15'd7;
  assign need_g = (need_b[14:3] < 12'(SPLIT_G)) ? 12'(SPLIT_G) : need_b[14:3];

  // free address check
  logic [bfa_pkg::ADDR_W-1:0] f_off;
  logic                       f_bad;
  assign f_off = address_i - bfa_pkg::ADDR_W'(HEADER_BYTES);
  assign f_bad = (13'(address_i) < 13'(HEADER_BYTES)) || (f_off[2:0] != 3'd0) ||
                 (FW'(f_off[11:3]) >= FW'(pool_gran_q));

  // split and neighbor arithmetic
  logic [XW-1:0] a_rem, a_n, f_n;
  logic          a_split;
  logic [bfa_pkg::ADDR_W-1:0] a_addr;
  assign a_rem   = XW'(best_gran_q) - XW'(need_q);
  assign a_n     = XW'(best_idx_q) + XW'(need_q);
  assign a_split = (a_rem >= XW'(SPLIT_G)) && (a_n < XW'(NGRAN));
  assign a_addr  = bfa_pkg::ADDR_W'(32'(best_idx_q) * 8 + 32'(HEADER_BYTES));
  assign f_n     = XW'(cur_q) + XW'(cur_gran_q);

  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    chk_v_d      = chk_v_q;
    chk_idx_d    = chk_idx_q;
    walk_more_d  = walk_more_q;
    need_d       = need_q;
    g_d          = g_q;
    cur_d        = cur_q;
    cur_gran_d   = cur_gran_q;
    cur_stamp_d  = cur_stamp_q;
    n_d          = n_q;
    best_v_d     = best_v_q;
    best_idx_d   = best_idx_q;
    best_gran_d  = best_gran_q;
    best_stamp_d = best_stamp_q;
    stamp_d      = stamp_q;
    ready_d      = ready_q;
    pool_gran_d  = pool_gran_q;
    done_d       = 1'b0;
    status_d     = status_q;
    addr_d       = addr_q;
    mem_we       = 1'b0;
    mem_wa       = g_q;
    mem_ws       = 1'b0;
    mem_wf       = 1'b0;
    mem_wg       = '0;
    mem_wt       = '0;
    mem_ra       = idx_q[IW-1:0];

    case (state_q)
      S_IDLE: begin
        if (start) begin
          case (action_i)
            bfa_pkg::ACT_ALLOC: begin
              if (!ready_q || (req_bytes_i == '0)) begin
                done_d   = 1'b1;
                status_d = bfa_pkg::ST_NOFIT;
                addr_d   = '0;
              end else begin
                need_d   = need_g;
                idx_d    = '0;
                chk_v_d  = 1'b0;
                best_v_d = 1'b0;
                state_d  = S_SCAN;
              end
            end
            bfa_pkg::ACT_FREE: begin
              if (!ready_q || f_bad) begin
                done_d   = 1'b1;
                status_d = bfa_pkg::ST_BADFREE;
                addr_d   = '0;
              end else begin
                g_d     = IW'(FW'(f_off[11:3]));
                mem_ra  = IW'(FW'(f_off[11:3]));
                state_d = S_F_CHK;
              end
            end
            bfa_pkg::ACT_INIT: begin
              if (!init_ok) begin
                done_d   = 1'b1;
                status_d = bfa_pkg::ST_INITF;
                addr_d   = '0;
              end else begin
                pool_gran_d = init_gran;
                ready_d     = 1'b0;
                idx_d       = '0;
                state_d     = S_INIT;
              end
            end
            default: begin
              done_d   = 1'b1;
              status_d = bfa_pkg::ST_NOFIT;
              addr_d   = '0;
            end
          endcase
        end
      end

      // clear every table entry
      S_INIT: begin
        mem_we = 1'b1;
        mem_wa = idx_q[IW-1:0];
        idx_d  = idx_q + 1'b1;
        if (idx_q == (IW+1)'(NGRAN - 1)) begin
          state_d = S_INIT_W;
        end
      end

      // one free block covering the pool
      S_INIT_W: begin
        mem_we   = 1'b1;
        mem_wa   = '0;
        mem_ws   = 1'b1;
        mem_wf   = 1'b1;
        mem_wg   = pool_gran_q;
        mem_wt   = stamp_q;
        stamp_d  = stamp_q + 1'b1;
        ready_d  = 1'b1;
        done_d   = 1'b1;
        status_d = bfa_pkg::ST_OK;
        addr_d   = '0;
        state_d  = S_IDLE;
      end

      // read one granule per cycle, compare the one read last cycle
      S_SCAN: begin
        if (idx_q < (IW+1)'(pool_gran_q)) begin
          mem_ra    = idx_q[IW-1:0];
          idx_d     = idx_q + 1'b1;
          chk_v_d   = 1'b1;
          chk_idx_d = idx_q[IW-1:0];
        end else begin
          chk_v_d = 1'b0;
          if (!chk_v_q) begin
            state_d = S_A_WR;
          end
        end
        if (chk_v_q && take) begin
          best_v_d     = 1'b1;
          best_idx_d   = chk_idx_q;
          best_gran_d  = rd_g;
          best_stamp_d = rd_t;
        end
      end

      S_A_WR: begin
        if (!best_v_q) begin
          done_d   = 1'b1;
          status_d = bfa_pkg::ST_NOFIT;
          addr_d   = '0;
          state_d  = S_IDLE;
        end else begin
          mem_we = 1'b1;
          mem_wa = best_idx_q;
          mem_ws = 1'b1;
          mem_wf = 1'b0;
          mem_wg = a_split ? GW'(need_q) : best_gran_q;
          mem_wt = best_stamp_q;
          if (a_split) begin
            n_d        = IW'(a_n);
            cur_gran_d = GW'(a_rem);
            state_d    = S_A_SPL;
          end else begin
            done_d   = 1'b1;
            status_d = bfa_pkg::ST_OK;
            addr_d   = a_addr;
            state_d  = S_IDLE;
          end
        end
      end

      // free remainder after the allocated block
      S_A_SPL: begin
        mem_we   = 1'b1;
        mem_wa   = n_q;
        mem_ws   = 1'b1;
        mem_wf   = 1'b1;
        mem_wg   = cur_gran_q;
        mem_wt   = stamp_q;
        stamp_d  = stamp_q + 1'b1;
        done_d   = 1'b1;
        status_d = bfa_pkg::ST_OK;
        addr_d   = a_addr;
        state_d  = S_IDLE;
      end

      S_F_CHK: begin
        if (!rd_s || rd_f) begin
          done_d   = 1'b1;
          status_d = bfa_pkg::ST_BADFREE;
          addr_d   = '0;
          state_d  = S_IDLE;
        end else begin
          cur_d      = g_q;
          cur_gran_d = rd_g;
          if (g_q == '0) begin
            state_d = S_F_MARK;
          end else begin
            idx_d       = (IW+1)'(g_q) - 1'b1;
            walk_more_d = 1'b1;
            chk_v_d     = 1'b0;
            state_d     = S_F_WALK;
          end
        end
      end

      // walk down to the previous block start
      S_F_WALK: begin
        if (walk_more_q) begin
          mem_ra    = idx_q[IW-1:0];
          chk_v_d   = 1'b1;
          chk_idx_d = idx_q[IW-1:0];
          if (idx_q == '0) begin
            walk_more_d = 1'b0;
          end else begin
            idx_d = idx_q - 1'b1;
          end
        end else begin
          chk_v_d = 1'b0;
        end
        if (chk_v_q) begin
          if (rd_s) begin
            if (rd_f) begin
              mem_we      = 1'b1;
              mem_wa      = chk_idx_q;
              mem_ws      = 1'b1;
              mem_wf      = 1'b1;
              mem_wg      = rd_g + cur_gran_q;
              mem_wt      = rd_t;
              cur_d       = chk_idx_q;
              cur_gran_d  = rd_g + cur_gran_q;
              cur_stamp_d = rd_t;
              state_d     = S_F_CLRG;
            end else begin
              state_d = S_F_MARK;
            end
          end else if (chk_idx_q == '0) begin
            state_d = S_F_MARK;
          end
        end
      end

      // block merged into its predecessor
      S_F_CLRG: begin
        mem_we  = 1'b1;
        mem_wa  = g_q;
        state_d = S_F_NRD;
      end

      S_F_MARK: begin
        mem_we      = 1'b1;
        mem_wa      = g_q;
        mem_ws      = 1'b1;
        mem_wf      = 1'b1;
        mem_wg      = cur_gran_q;
        mem_wt      = stamp_q;
        cur_stamp_d = stamp_q;
        stamp_d     = stamp_q + 1'b1;
        state_d     = S_F_NRD;
      end

      // look at the next physical block
      S_F_NRD: begin
        if ((f_n < XW'(pool_gran_q)) && (f_n < XW'(NGRAN))) begin
          mem_ra  = IW'(f_n);
          n_d     = IW'(f_n);
          state_d = S_F_NCHK;
        end else begin
          done_d   = 1'b1;
          status_d = bfa_pkg::ST_OK;
          addr_d   = '0;
          state_d  = S_IDLE;
        end
      end

      S_F_NCHK: begin
        if (rd_s && rd_f) begin
          mem_we  = 1'b1;
          mem_wa  = cur_q;
          mem_ws  = 1'b1;
          mem_wf  = 1'b1;
          mem_wg  = cur_gran_q + rd_g;
          mem_wt  = cur_stamp_q;
          state_d = S_F_NCLR;
        end else begin
          done_d   = 1'b1;
          status_d = bfa_pkg::ST_OK;
          addr_d   = '0;
          state_d  = S_IDLE;
        end
      end

      S_F_NCLR: begin
        mem_we   = 1'b1;
        mem_wa   = n_q;
        done_d   = 1'b1;
        status_d = bfa_pkg::ST_OK;
        addr_d   = '0;
        state_d  = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      chk_v_q     <= 1'b0;
      walk_more_q <= 1'b0;
      best_v_q    <= 1'b0;
      stamp_q     <= '0;
      ready_q     <= 1'b0;
      pool_gran_q <= '0;
      cfg_q       <= bfa_pkg::CFG_RESET;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      chk_v_q     <= chk_v_d;
      walk_more_q <= walk_more_d;
      best_v_q    <= best_v_d;
      stamp_q     <= stamp_d;
      ready_q     <= ready_d;
      pool_gran_q <= pool_gran_d;
      done_q      <= done_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_q <= cfg_data_i;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    chk_idx_q    <= chk_idx_d;
    need_q       <= need_d;
    g_q          <= g_d;
    cur_q        <= cur_d;
    cur_gran_q   <= cur_gran_d;
    cur_stamp_q  <= cur_stamp_d;
    n_q          <= n_d;
    best_idx_q   <= best_idx_d;
    best_gran_q  <= best_gran_d;
    best_stamp_q <= best_stamp_d;
    status_q     <= status_d;
    addr_q       <= addr_d;
  end

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign data_address_o = addr_q;

  // a result is shown only once the sequencer is back in idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while busy");

  // an accepted request either answers at once or keeps the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o))
    else $error("accepted request dropped");

  // a nonzero data address only comes with a successful allocate
  a_addr_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (data_address_o != '0)) |-> (status_o == bfa_pkg::ST_OK))
    else $error("address with failing status");

endmodule

// ===== hw/rtl/bfa_mem.sv =====
`timescale 1ns / 1ps

// Granule table: start, free, size, free-list stamp. One write, one registered read.
module bfa_mem #(
  parameter int IW = 9,
  parameter int GW = 10
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [IW-1:0]               waddr_i,
  input  logic                        wstart_i,
  input  logic                        wfree_i,
  input  logic [GW-1:0]               wgran_i,
  input  logic [bfa_pkg::STAMP_W-1:0] wstamp_i,
  input  logic [IW-1:0]               raddr_i,
  output logic                        rstart_o,
  output logic                        rfree_o,
  output logic [GW-1:0]               rgran_o,
  output logic [bfa_pkg::STAMP_W-1:0] rstamp_o
);

  localparam int DEPTH = 1 << IW;
  localparam int WW    = 2 + GW + bfa_pkg::STAMP_W;

  logic [WW-1:0] mem [DEPTH];
  logic [WW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= {wstart_i, wfree_i, wgran_i, wstamp_i};
    end
    rdata_q <= mem[raddr_i];
  end

  assign rstart_o = rdata_q[WW-1];
  assign rfree_o  = rdata_q[WW-2];
  assign rgran_o  = rdata_q[bfa_pkg::STAMP_W +: GW];
  assign rstamp_o = rdata_q[bfa_pkg::STAMP_W-1:0];

endmodule

// ===== hw/rtl/bfa_pick.sv =====
`timescale 1ns / 1ps

// Best-fit compare: smallest fitting free block, ties to the newer stamp.
module bfa_pick #(
  parameter int GW = 10
) (
  input  logic                        cand_start_i,
  input  logic                        cand_free_i,
  input  logic [GW-1:0]               cand_gran_i,
  input  logic [bfa_pkg::STAMP_W-1:0] cand_stamp_i,
  input  logic [bfa_pkg::NEED_W-1:0]  need_i,
  input  logic                        best_v_i,
  input  logic [GW-1:0]               best_gran_i,
  input  logic [bfa_pkg::STAMP_W-1:0] best_stamp_i,
  output logic                        take_o
);

  localparam int CW = (GW > bfa_pkg::NEED_W) ? GW : bfa_pkg::NEED_W;

  logic fits;
  logic better;

  assign fits   = CW'(cand_gran_i) >= CW'(need_i);
  assign better = !best_v_i || (cand_gran_i < best_gran_i) ||
                  ((cand_gran_i == best_gran_i) && (cand_stamp_i > best_stamp_i));
  assign take_o = cand_start_i && cand_free_i && fits && better;

endmodule

// ===== sim/tb_best_fit_block_allocator_unit.sv =====
`timescale 1ns / 1ps

module tb_best_fit_block_allocator_unit;

  localparam int NG     = bfa_pkg::POOL_BYTES_DEF / 8;
  localparam int HDR    = bfa_pkg::HEADER_BYTES_DEF;
  localparam int MSPLIT = bfa_pkg::MIN_SPLIT_DEF;
  localparam int LIMIT  = 4000000;
  localparam int N_RAND = 1050;

  typedef struct packed {
    logic [bfa_pkg::STAT_W-1:0] status;
    logic [bfa_pkg::ADDR_W-1:0] daddr;
  } alloc_result_t;

  typedef struct {
    logic [bfa_pkg::ACT_W-1:0]  act;
    logic [bfa_pkg::REQ_W-1:0]  req;
    logic [bfa_pkg::ADDR_W-1:0] addr;
    bit                         fixed;
    logic [bfa_pkg::STAT_W-1:0] st;
    logic [bfa_pkg::ADDR_W-1:0] da;
  } request_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [bfa_pkg::ACT_W-1:0] action_i = bfa_pkg::ACT_ALLOC;
  logic [bfa_pkg::REQ_W-1:0] req_bytes_i = '0;
  logic [bfa_pkg::ADDR_W-1:0] address_i = '0;
  logic done_o;
  logic [bfa_pkg::STAT_W-1:0] status_o;
  logic [bfa_pkg::ADDR_W-1:0] data_address_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [bfa_pkg::CFG_W-1:0] cfg_data_i = '0;

  // shadow allocator state
  bit          sh_start [NG];
  bit          sh_free  [NG];
  int unsigned sh_gran  [NG];
  bit [31:0]   sh_stamp [NG];
  bit [31:0]   sh_stamp_ctr;
  bit          sh_ready;
  int unsigned sh_pool_gran;
  int unsigned sh_pool_bytes;

  alloc_result_t pending_results[$];
  logic [bfa_pkg::ADDR_W-1:0] live_addrs[$];
  int err_cnt = 0;
  int cyc = 0;
  int idle_pct = 0;

  best_fit_block_allocator_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .action_i(action_i), .req_bytes_i(req_bytes_i), .address_i(address_i),
    .done_o(done_o), .status_o(status_o), .data_address_o(data_address_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // mark block free with the next list stamp
  function automatic void join_free(int unsigned g);
    sh_free[g] = 1'b1;
    sh_stamp[g] = sh_stamp_ctr;
    sh_stamp_ctr = sh_stamp_ctr + 32'd1;
  endfunction

  function automatic alloc_result_t predict_alloc(logic [bfa_pkg::ACT_W-1:0] act,
                                                  logic [bfa_pkg::REQ_W-1:0] req,
                                                  logic [bfa_pkg::ADDR_W-1:0] addr);
    alloc_result_t r;
    int unsigned bytes, need, best, rem, g, p, n, off;
    bit found;
    r.status = bfa_pkg::ST_OK;
    r.daddr = '0;
    found = 1'b0;
    best = 0;
    case (act)
      bfa_pkg::ACT_INIT: begin
        bytes = (sh_pool_bytes > bfa_pkg::POOL_BYTES_DEF) ? bfa_pkg::POOL_BYTES_DEF
                                                          : sh_pool_bytes;
        bytes = bytes & ~32'd7;
        if (bytes < MSPLIT || bytes < 8) begin
          r.status = bfa_pkg::ST_INITF;
        end else begin
          for (int i = 0; i < NG; i++) begin
            sh_start[i] = 1'b0;
            sh_free[i] = 1'b0;
          end
          sh_pool_gran = bytes / 8;
          sh_ready = 1'b1;
          sh_start[0] = 1'b1;
          sh_gran[0] = sh_pool_gran;
          join_free(0);
        end
      end
      bfa_pkg::ACT_ALLOC: begin
        if (!sh_ready || req == 0) begin
          r.status = bfa_pkg::ST_NOFIT;
        end else begin
          need = (32'(req) + HDR + 7) & ~32'd7;
          if (need < ((MSPLIT + 7) & ~32'd7)) need = (MSPLIT + 7) & ~32'd7;
          need = need / 8;
          for (g = 0; g < sh_pool_gran && g < NG; g++) begin
            if (sh_start[g] && sh_free[g] && sh_gran[g] >= need) begin
              if (!found || sh_gran[g] < sh_gran[best] ||
                  (sh_gran[g] == sh_gran[best] && sh_stamp[g] > sh_stamp[best])) begin
                best = g;
                found = 1'b1;
              end
            end
          end
          if (!found) begin
            r.status = bfa_pkg::ST_NOFIT;
          end else begin
            sh_free[best] = 1'b0;
            rem = sh_gran[best] - need;
            if (rem * 8 >= MSPLIT && best + need < NG) begin
              sh_gran[best] = need;
              sh_start[best + need] = 1'b1;
              sh_gran[best + need] = rem;
              join_free(best + need);
            end
            r.daddr = bfa_pkg::ADDR_W'(best * 8 + HDR);
          end
        end
      end
      bfa_pkg::ACT_FREE: begin
        off = 32'(addr) - HDR;
        g = off / 8;
        if (!sh_ready || addr < HDR || off[2:0] != 0 || g >= sh_pool_gran || g >= NG ||
            !sh_start[g] || sh_free[g]) begin
          r.status = bfa_pkg::ST_BADFREE;
        end else begin
          // find the physically previous block
          p = g;
          while (p > 0) begin
            p--;
            if (sh_start[p]) break;
          end
          if (g > 0 && sh_start[p] && sh_free[p]) begin
            sh_gran[p] += sh_gran[g];
            sh_start[g] = 1'b0;
            g = p;
          end else begin
            join_free(g);
          end
          n = g + sh_gran[g];
          if (n < sh_pool_gran && n < NG && sh_start[n] && sh_free[n]) begin
            sh_gran[g] += sh_gran[n];
            sh_start[n] = 1'b0;
            sh_free[n] = 1'b0;
          end
        end
      end
      default: r.status = bfa_pkg::ST_NOFIT;
    endcase
    return r;
  endfunction

  // keep the list of live data addresses in step with the shadow state
  function automatic void track_live(logic [bfa_pkg::ACT_W-1:0] act,
                                     logic [bfa_pkg::ADDR_W-1:0] addr,
                                     alloc_result_t r);
    if (act == bfa_pkg::ACT_INIT && r.status == bfa_pkg::ST_OK) live_addrs.delete();
    if (act == bfa_pkg::ACT_ALLOC && r.status == bfa_pkg::ST_OK)
      live_addrs.push_back(r.daddr);
    if (act == bfa_pkg::ACT_FREE && r.status == bfa_pkg::ST_OK) begin
      for (int i = 0; i < live_addrs.size(); i++) begin
        if (live_addrs[i] == addr) begin
          live_addrs.delete(i);
          break;
        end
      end
    end
  endfunction

  // issue one request and record its expected result on acceptance
  task automatic issue_request(request_row_t row);
    alloc_result_t r;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start <= 1'b1;
    action_i <= row.act;
    req_bytes_i <= row.req;
    address_i <= row.addr;
    do @(posedge clk_i); while (busy);
    r = predict_alloc(row.act, row.req, row.addr);
    track_live(row.act, row.addr, r);
    if (row.fixed) begin
      r.status = row.st;
      r.daddr = row.da;
    end
    pending_results.push_back(r);
  endtask

  // register write, only while idle
  task automatic write_pool_len(int unsigned v);
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0 || busy) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v[bfa_pkg::CFG_W-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    sh_pool_bytes = v & 32'h1FFF;
    cfg_valid_i <= 1'b0;
  endtask

  function automatic request_row_t pick_random();
    request_row_t row;
    int unsigned k;
    row.fixed = 1'b0;
    row.st = '0;
    row.da = '0;
    row.req = bfa_pkg::REQ_W'($urandom_range(1, 160));
    row.addr = bfa_pkg::ADDR_W'($urandom_range(0, 4095));
    k = $urandom_range(99);
    if (k < 46) begin
      row.act = bfa_pkg::ACT_ALLOC;
      if ($urandom_range(9) == 0) row.req = bfa_pkg::REQ_W'($urandom_range(0, 8191));
      else if ($urandom_range(9) == 0)
        row.req = bfa_pkg::REQ_W'($urandom_range(161, 1200));
    end else if (k < 86) begin
      row.act = bfa_pkg::ACT_FREE;
      if (live_addrs.size() != 0)
        row.addr = live_addrs[$urandom_range(0, live_addrs.size() - 1)];
    end else if (k < 94) begin
      row.act = bfa_pkg::ACT_FREE;
    end else if (k < 97) begin
      row.act = bfa_pkg::ACT_INIT;
    end else begin
      row.act = bfa_pkg::ACT_RSVD;
    end
    return row;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    alloc_result_t e;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: status %0d", status_o);
        err_cnt++;
      end else begin
        e = pending_results.pop_front();
        if (status_o !== e.status) begin
          $error("status: expected %0d, actual %0d", e.status, status_o);
          err_cnt++;
        end
        if (data_address_o !== e.daddr) begin
          $error("data_address: expected %0d, actual %0d", e.daddr, data_address_o);
          err_cnt++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cyc++;
    if (cyc > LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  request_row_t directed[] = '{
    '{bfa_pkg::ACT_ALLOC, 13'd8,    12'd0,    1'b1, bfa_pkg::ST_NOFIT,   12'd0},
    '{bfa_pkg::ACT_FREE,  13'd0,    12'd40,   1'b1, bfa_pkg::ST_BADFREE, 12'd0},
    '{bfa_pkg::ACT_RSVD,  13'd0,    12'd0,    1'b1, bfa_pkg::ST_NOFIT,   12'd0},
    '{bfa_pkg::ACT_INIT,  13'd0,    12'd0,    1'b1, bfa_pkg::ST_OK,      12'd0},
    '{bfa_pkg::ACT_ALLOC, 13'd0,    12'd0,    1'b1, bfa_pkg::ST_NOFIT,   12'd0},
    '{bfa_pkg::ACT_ALLOC, 13'd4096, 12'd0,    1'b1, bfa_pkg::ST_NOFIT,   12'd0},
    '{bfa_pkg::ACT_ALLOC, 13'd8191, 12'd0,    1'b1, bfa_pkg::ST_NOFIT,   12'd0},
    '{bfa_pkg::ACT_ALLOC, 13'd1,    12'd0,    1'b1, bfa_pkg::ST_OK,      12'd40},
    '{bfa_pkg::ACT_FREE,  13'd0,    12'd0,    1'b1, bfa_pkg::ST_BADFREE, 12'd0},
    '{bfa_pkg::ACT_FREE,  13'd0,    12'd41,   1'b1, bfa_pkg::ST_BADFREE, 12'd0},
    '{bfa_pkg::ACT_FREE,  13'd0,    12'd4095, 1'b1, bfa_pkg::ST_BADFREE, 12'd0},
    '{bfa_pkg::ACT_FREE,  13'd0,    12'd40,   1'b1, bfa_pkg::ST_OK,      12'd0},
    '{bfa_pkg::ACT_FREE,  13'd0,    12'd40,   1'b1, bfa_pkg::ST_BADFREE, 12'd0},
    '{bfa_pkg::ACT_ALLOC, 13'd4056, 12'd0,    1'b1, bfa_pkg::ST_OK,      12'd40},
    '{bfa_pkg::ACT_ALLOC, 13'd1,    12'd0,    1'b1, bfa_pkg::ST_NOFIT,   12'd0},
    '{bfa_pkg::ACT_FREE,  13'd0,    12'd40,   1'b1, bfa_pkg::ST_OK,      12'd0},
    '{bfa_pkg::ACT_ALLOC, 13'd100,  12'd0,    1'b0, bfa_pkg::ST_OK,      12'd0},
    '{bfa_pkg::ACT_ALLOC, 13'd24,   12'd0,    1'b0, bfa_pkg::ST_OK,      12'd0},
    '{bfa_pkg::ACT_ALLOC, 13'd100,  12'd0,    1'b0, bfa_pkg::ST_OK,      12'd0},
    '{bfa_pkg::ACT_FREE,  13'd0,    12'd40,   1'b0, bfa_pkg::ST_OK,      12'd0},
    '{bfa_pkg::ACT_ALLOC, 13'd100,  12'd0,    1'b0, bfa_pkg::ST_OK,      12'd0},
    '{bfa_pkg::ACT_FREE,  13'd0,    12'd176,  1'b0, bfa_pkg::ST_OK,      12'd0},
    '{bfa_pkg::ACT_FREE,  13'd0,    12'd4088, 1'b0, bfa_pkg::ST_OK,      12'd0},
    '{bfa_pkg::ACT_INIT,  13'd0,    12'd0,    1'b0, bfa_pkg::ST_OK,      12'd0}
  };

  int unsigned pool_settings[] = '{0, 8191, 24, 32, 37, 1000, 4095, 4096};

  initial begin
    int per_phase;
    for (int i = 0; i < NG; i++) begin
      sh_start[i] = 1'b0;
      sh_free[i] = 1'b0;
      sh_gran[i] = 0;
      sh_stamp[i] = '0;
    end
    sh_stamp_ctr = '0;
    sh_ready = 1'b0;
    sh_pool_gran = 0;
    sh_pool_bytes = 32'(bfa_pkg::CFG_RESET);
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idle_pct = 36;
    foreach (directed[i]) issue_request(directed[i]);

    // random requests across several pool lengths
    per_phase = N_RAND / pool_settings.size();
    foreach (pool_settings[p]) begin
      write_pool_len(p == 4 ? $urandom_range(0, 8191) : pool_settings[p]);
      issue_request('{bfa_pkg::ACT_INIT, 13'd0, 12'd0, 1'b0, bfa_pkg::ST_OK, 12'd0});
      for (int k = 0; k < per_phase; k++) begin
        idle_pct = (p < 3) ? 36 : (p < 6) ? 67 : 0;
        issue_request(pick_random());
      end
    end

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
